// ===== hw/rtl/asd_pkg.sv =====
// asd_pkg: shared types for the address sort and dedup block.
// Holds the key type and the status bundle from the cell chain to the control.
// No dependencies.
`default_nettype none

package asd_pkg;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned KEY_W   = 2 * FIELD_W;

  typedef logic [KEY_W-1:0] key_t;

  // What the control needs to see of the chain
  typedef struct packed {
    logic head_v;
    key_t head_key;
    logic second_v;
    key_t second_key;
    logic busy;
  } chain_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/asd_cell.sv =====
// asd_cell: one cell of the insertion sorter chain.
// Keeps the smaller key, hands the larger one on; shifts towards the head when told.
// Depends on asd_pkg.
`default_nettype none

module asd_cell
  import asd_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  shift,
  input  wire  in_v,
  input  key_t in_key,
  input  wire  right_v,
  input  key_t right_key,
  output logic stored_v,
  output key_t stored_key,
  output logic pass_v,
  output key_t pass_key
);

  logic stored_v_r, stored_v_nxt;
  key_t stored_key_r, stored_key_nxt;
  logic pass_v_r, pass_v_nxt;
  key_t pass_key_r, pass_key_nxt;

  always_comb begin
    stored_v_nxt   = stored_v_r;
    stored_key_nxt = stored_key_r;
    pass_v_nxt     = 1'b0;
    pass_key_nxt   = in_key;
    if (shift) begin
      stored_v_nxt   = right_v;
      stored_key_nxt = right_key;
    end else if (in_v) begin
      if (!stored_v_r) begin
        stored_v_nxt   = 1'b1;
        stored_key_nxt = in_key;
      end else if (in_key < stored_key_r) begin
        // keep the smaller key, push the old one on
        stored_key_nxt = in_key;
        pass_v_nxt     = 1'b1;
        pass_key_nxt   = stored_key_r;
      end else begin
        pass_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_v_r <= 1'b0;
      pass_v_r   <= 1'b0;
    end else begin
      stored_v_r <= stored_v_nxt;
      pass_v_r   <= pass_v_nxt;
    end
    stored_key_r <= stored_key_nxt;
    pass_key_r   <= pass_key_nxt;
  end

  assign stored_v   = stored_v_r;
  assign stored_key = stored_key_r;
  assign pass_v     = pass_v_r;
  assign pass_key   = pass_key_r;

endmodule

`default_nettype wire

// ===== hw/rtl/asd_chain.sv =====
// asd_chain: row of sorter cells, smallest key at the head.
// Depends on asd_pkg and asd_cell.
`default_nettype none

module asd_chain
  import asd_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           shift,
  input  wire           ins_v,
  input  key_t          ins_key,
  output chain_status_t status
);

  logic [DEPTH-1:0] st_v;
  key_t             st_key [DEPTH];
  logic [DEPTH-1:0] ps_v;
  key_t             ps_key [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic c_in_v;
    key_t c_in_key;
    logic c_right_v;
    key_t c_right_key;

    if (i == 0) begin : g_head
      assign c_in_v   = ins_v;
      assign c_in_key = ins_key;
    end else begin : g_body
      assign c_in_v   = ps_v[i-1];
      assign c_in_key = ps_key[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign c_right_v   = 1'b0;
      assign c_right_key = '0;
    end else begin : g_inner
      assign c_right_v   = st_v[i+1];
      assign c_right_key = st_key[i+1];
    end

    asd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift     (shift),
      .in_v      (c_in_v),
      .in_key    (c_in_key),
      .right_v   (c_right_v),
      .right_key (c_right_key),
      .stored_v  (st_v[i]),
      .stored_key(st_key[i]),
      .pass_v    (ps_v[i]),
      .pass_key  (ps_key[i])
    );
  end

  assign status.head_v     = st_v[0];
  assign status.head_key   = st_key[0];
  assign status.second_v   = st_v[1];
  assign status.second_key = st_key[1];
  // any key still travelling down the row
  assign status.busy       = |ps_v;

endmodule

`default_nettype wire

// ===== hw/rtl/address_sort_dedup.sv =====
// address_sort_dedup: sorts a set of (net, node) addresses and drops duplicates.
// Depends on asd_pkg and asd_chain.
//
// Input channel (in_valid / in_stall): one address per request, net and node,
// in_final_entry on the last address of a set. Requests are taken one per cycle
// while a set is loading; the first MAX_ENTRIES addresses are kept, later ones
// are ignored and flagged. Each key enters a row of MAX_ENTRIES cells and ripples
// one cell per cycle to its sorted place.
// After the final request, in_stall stays high while the row settles, then the
// distinct addresses leave in ascending order, net first then node, one per cycle
// while out_stall allows, from the head of the row. Each dropped duplicate is
// shifted out of the row without a result. The last result carries out_run_end
// and, if later addresses were ignored, out_dropped.
// Output channel (out_valid / out_stall): results sit in an output register; while
// out_stall is high on a valid result the register holds and the row shifts only
// to drop duplicates. After the last result has entered it, the next set may load.
// Reset (synchronous, rst_n low) empties the row and clears the count and flag.
`default_nettype none

module address_sort_dedup
  import asd_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [FIELD_W-1:0] in_key_net,
  input  wire  [FIELD_W-1:0] in_key_node,
  input  wire                in_final_entry,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [FIELD_W-1:0] out_net,
  output logic [FIELD_W-1:0] out_node,
  output logic               out_run_end,
  output logic               out_dropped
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {LOAD, SETTLE, EMIT} state_t;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic            ovf_r, ovf_nxt;
  logic            out_v_r, out_v_nxt;
  logic [FIELD_W-1:0] out_net_r, out_net_nxt;
  logic [FIELD_W-1:0] out_node_r, out_node_nxt;
  logic            out_end_r, out_end_nxt;
  logic            out_drop_r, out_drop_nxt;

  chain_status_t   cs;
  logic            accept, room, ins_v, dup, out_free, pop, emit;

  assign accept   = in_valid && (state_r == LOAD);
  assign room     = count_r < CNT_W'(MAX_ENTRIES);
  assign ins_v    = accept && room;
  assign dup      = cs.second_v && (cs.second_key == cs.head_key);
  assign out_free = !out_v_r || !out_stall;
  assign pop      = (state_r == EMIT) && cs.head_v && (dup || out_free);
  assign emit     = pop && !dup;

  asd_chain #(.DEPTH(MAX_ENTRIES)) u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .shift  (pop),
    .ins_v  (ins_v),
    .ins_key({in_key_net, in_key_node}),
    .status (cs)
  );

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    out_v_nxt    = out_v_r && out_stall;
    out_net_nxt  = out_net_r;
    out_node_nxt = out_node_r;
    out_end_nxt  = out_end_r;
    out_drop_nxt = out_drop_r;

    unique case (state_r)
      LOAD: begin
        if (accept) begin
          if (room) count_nxt = count_r + 1'b1;
          else      ovf_nxt   = 1'b1;
          if (in_final_entry) state_nxt = SETTLE;
        end
      end
      SETTLE: begin
        if (!cs.busy) state_nxt = EMIT;
      end
      EMIT: begin
        if (!cs.head_v) begin
          state_nxt = LOAD;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: state_nxt = LOAD;
    endcase

    // emit the last copy of each run; it closes the set when nothing follows
    if (emit) begin
      out_v_nxt    = 1'b1;
      out_net_nxt  = cs.head_key[KEY_W-1:FIELD_W];
      out_node_nxt = cs.head_key[FIELD_W-1:0];
      out_end_nxt  = !cs.second_v;
      out_drop_nxt = !cs.second_v && ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      out_v_r <= out_v_nxt;
    end
    out_net_r  <= out_net_nxt;
    out_node_r <= out_node_nxt;
    out_end_r  <= out_end_nxt;
    out_drop_r <= out_drop_nxt;
  end

  assign in_stall    = (state_r != LOAD);
  assign out_valid   = out_v_r;
  assign out_net     = out_net_r;
  assign out_node    = out_node_r;
  assign out_run_end = out_end_r;
  assign out_dropped = out_drop_r;

endmodule

`default_nettype wire

// ===== hw/rtl/asd_checker.sv =====
// asd_checker: port-level assertions for address_sort_dedup, bound to the top level.
// Depends on asd_pkg.
`default_nettype none

module asd_checker
  import asd_pkg::*;
(
  input wire               clk,
  input wire               rst_n,
  input wire               in_valid,
  input wire               in_stall,
  input wire [FIELD_W-1:0] in_key_net,
  input wire [FIELD_W-1:0] in_key_node,
  input wire               in_final_entry,
  input wire               out_valid,
  input wire               out_stall,
  input wire [FIELD_W-1:0] out_net,
  input wire [FIELD_W-1:0] out_node,
  input wire               out_run_end,
  input wire               out_dropped
);

  // reset leaves the block empty and ready for a new set
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // the closing request of a set holds off further input
  a_final_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_final_entry |=> in_stall)
    else $error("input not held after final request");

  // overflow is reported on the closing result only
  a_drop_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_end |-> !out_dropped)
    else $error("dropped flag on a non-closing result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_net) && $stable(out_node)
                               && $stable(out_run_end) && $stable(out_dropped))
    else $error("stalled result changed");

endmodule

bind address_sort_dedup asd_checker u_asd_checker (.*);

`default_nettype wire
